// ===== hw/rtl/rnse_pkg.sv =====
// Shared types and constants for the RPN nibble stack evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rnse_pkg;

   localparam int CODE_W          = 4;
   localparam int RESULT_W        = 32;
   localparam int DEF_STACK_DEPTH = 8;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam logic [CODE_W-1:0] CODE_DIGIT_MAX = 4'd9;
   localparam logic [CODE_W-1:0] CODE_ADD       = 4'd10;
   localparam logic [CODE_W-1:0] CODE_SUB       = 4'd11;
   localparam logic [CODE_W-1:0] CODE_MUL       = 4'd12;

   // Movement of the cell row for one transfer.
   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_DOWN,   // push: each cell takes its upper neighbor
      SHIFT_UP      // binary op: top takes the result, the rest close the gap
   } shift_type;

   typedef struct packed {
      logic      en;
      shift_type dir;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rpn_nibble_stack_evaluator_core.sv =====
// RPN nibble stack evaluator. Takes one 4-bit code per cycle while no result waits unaccepted:
// digits 0-9 push, 10/11/12 replace the top two entries b,a by b+a, b-a, b*a (wrapping), other
// codes and operators on fewer than two entries change nothing, and a push onto a full stack is
// dropped and remembered. The transfer marked with tlast ends the expression: its code is
// applied, then one result carries the new top (sign-extended or cut to 32 bits), an empty flag
// and the dropped-push flag, and the stack clears. The add/sub/mul on the top cell pair is
// combinational; the registered result appears in the cycle after the last transfer. The stack
// is a row of STACK_DEPTH cells that shift as a whole, so there is no clearing pass after reset.
`default_nettype none

module rpn_nibble_stack_evaluator_core
   import rnse_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [3:0] code, [7:4] zero
   input  wire logic          req_tlast,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,   // [31:0] value
   output logic [1:0]         rsp_tuser    // [0] empty_res, [1] overflowed
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic                   take;
   logic [CODE_W-1:0]      code;
   logic                   is_digit;
   logic                   is_op;
   logic                   push_ok;
   logic                   done;
   logic [VALUE_WIDTH-1:0] push_val;
   logic [VALUE_WIDTH-1:0] alu_res;
   logic [VALUE_WIDTH-1:0] top_next;
   logic [VALUE_WIDTH-1:0] cell_q [STACK_DEPTH];
   cell_ctrl_type          ctrl;

   logic [CNT_W-1:0]       count_ff, count_in, count_next;
   logic                   ovf_ff, ovf_in, ovf_next;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic [RESULT_W-1:0]    top_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign code       = req_tdata[CODE_W-1:0];
   assign done       = take && req_tlast;

   assign is_digit = (code <= CODE_DIGIT_MAX);
   assign is_op    = (code == CODE_ADD || code == CODE_SUB || code == CODE_MUL)
                     && (count_ff >= CNT_W'(2));
   assign push_ok  = (count_ff < CNT_W'(STACK_DEPTH));
   assign push_val = {{(VALUE_WIDTH-CODE_W){1'b0}}, code};

   always_comb begin
      ctrl.en  = take;
      ctrl.dir = SHIFT_HOLD;
      if (is_digit && push_ok) begin
         ctrl.dir = SHIFT_DOWN;
      end else if (is_op) begin
         ctrl.dir = SHIFT_UP;
      end
   end

   rnse_alu #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_alu (
      .code   (code),
      .a_val  (cell_q[0]),
      .b_val  (cell_q[1]),
      .result (alu_res)
   );

   // Top takes the pushed digit or op result; others shift one place; bottom holds on a pop.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_val;
      logic [VALUE_WIDTH-1:0] next_val;
      if (i == 0) begin : g_top
         assign prev_val = push_val;
         assign next_val = alu_res;
      end else if (i == STACK_DEPTH - 1) begin : g_bottom
         assign prev_val = cell_q[i-1];
         assign next_val = cell_q[i];
      end else begin : g_mid
         assign prev_val = cell_q[i-1];
         assign next_val = cell_q[i+1];
      end
      rnse_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .from_prev (prev_val),
         .from_next (next_val),
         .data_out  (cell_q[i])
      );
   end

   always_comb begin
      count_next = count_ff;
      top_next   = cell_q[0];
      if (is_digit && push_ok) begin
         count_next = count_ff + CNT_W'(1);
         top_next   = push_val;
      end else if (is_op) begin
         count_next = count_ff - CNT_W'(1);
         top_next   = alu_res;
      end
      ovf_next = ovf_ff || (is_digit && !push_ok);
   end

   if (VALUE_WIDTH >= RESULT_W) begin : g_cut
      assign top_ext = top_next[RESULT_W-1:0];
   end else begin : g_sext
      assign top_ext = {{(RESULT_W-VALUE_WIDTH){top_next[VALUE_WIDTH-1]}}, top_next};
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (take) begin
         count_in = count_next;
         ovf_in   = ovf_next;
      end
      if (done) begin
         // Emit the result and clear the stack for the next expression.
         count_in     = '0;
         ovf_in       = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_empty_in = (count_next == '0);
         rsp_value_in = (count_next == '0) ? '0 : top_ext;
         rsp_ovf_in   = ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff && count_ff == '0 && !ovf_ff)
      else $error("expression end did not emit and clear");

   a_drop_flagged: assert property (@(posedge clock) disable iff (reset)
      take && !req_tlast && is_digit && !push_ok |=> ovf_ff)
      else $error("dropped push not flagged");

   a_empty_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_value_ff == '0)
      else $error("empty result with nonzero value");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rnse_alu.sv =====
// Arithmetic unit for the top two stack entries: b+a, b-a, b*a, wrapping.
// Depends on rnse_pkg.
`default_nettype none

module rnse_alu
   import rnse_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic [CODE_W-1:0]      code,
   input  wire logic [VALUE_WIDTH-1:0] a_val,
   input  wire logic [VALUE_WIDTH-1:0] b_val,
   output logic      [VALUE_WIDTH-1:0] result
);

   always_comb begin
      unique case (code)
         CODE_ADD: result = b_val + a_val;
         CODE_SUB: result = b_val - a_val;
         CODE_MUL: result = b_val * a_val;
         default:  result = b_val + a_val;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rnse_cell.sv =====
// One stack entry of the shift-register stack.
// Depends on rnse_pkg for the cell control struct.
`default_nettype none

module rnse_cell
   import rnse_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic                   clock,
   input  wire cell_ctrl_type          ctrl,
   input  wire logic [VALUE_WIDTH-1:0] from_prev,
   input  wire logic [VALUE_WIDTH-1:0] from_next,
   output logic      [VALUE_WIDTH-1:0] data_out
);

   logic [VALUE_WIDTH-1:0] data_ff;
   logic [VALUE_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.en) begin
         unique case (ctrl.dir)
            SHIFT_DOWN: data_in = from_prev;
            SHIFT_UP:   data_in = from_next;
            default:    data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire
